FILE: hw/rtl/v3alu_pkg.sv
// Shared constants, types and the saturating clamp for the 3D vector unit.
package v3alu_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int WORD_BITS    = 32;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int ACC_BITS     = PROD_BITS + 2;
    localparam int ROOT_BITS    = WORD_BITS;
    localparam int DVD_BITS     = WORD_BITS + FRAC_BITS;
    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = ROOT_BITS;
    localparam int DIV_STAGES   = DVD_BITS;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_SUB   = 4'd1,
        FN_SCALE = 4'd2,
        FN_DIV   = 4'd3,
        FN_CROSS = 4'd4,
        FN_DOT   = 4'd5,
        FN_LENSQ = 4'd6,
        FN_LEN   = 4'd7,
        FN_NORM  = 4'd8
    } t_func;

    // Operands that ride along with an item to the late stages.
    typedef struct packed {
        logic [3:0]  func;
        t_word [2:0] a;
        t_word       s;
    } t_item;

    // Item plus the results that the front end already settled.
    typedef struct packed {
        t_item       it;
        t_word [2:0] r;
        t_word       rs;
        logic        sat;
    } t_tag;

    typedef struct packed {
        logic       den_zero;
        logic [2:0] neg;
    } t_dinfo;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_clamp;

    // Clamp a wide signed value into the word range.
    function automatic t_clamp clamp_acc(input logic signed [ACC_BITS-1:0] v);
        t_clamp c;
        c.sat = !((&v[ACC_BITS-1:WORD_BITS-1]) || !(|v[ACC_BITS-1:WORD_BITS-1]));
        c.val = c.sat ? (v[ACC_BITS-1] ? WORD_MIN : WORD_MAX) : v[WORD_BITS-1:0];
        return c;
    endfunction

endpackage

FILE: hw/rtl/v3alu_front.sv
// Front end: operand select, six multipliers, sums, rescale and clamp.
module v3alu_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [3:0]                         i_func,
    input  v3alu_pkg::t_word [2:0]             i_a,
    input  v3alu_pkg::t_word [2:0]             i_b,
    input  v3alu_pkg::t_word                   i_s,
    output logic                               o_valid,
    output v3alu_pkg::t_tag                    o_tag,
    output logic [v3alu_pkg::PROD_BITS-1:0]    o_rad
);
    import v3alu_pkg::*;

    localparam logic signed [ACC_BITS-1:0] BIAS = ACC_BITS'((2**FRAC_BITS) - 1);

    // stage 1
    logic        r_v1;
    t_item       r_it1;
    t_word [2:0] r_b1;
    // stage 2
    logic                        r_v2;
    t_item                       r_it2;
    logic signed [PROD_BITS-1:0] r_p [6];
    logic signed [PROD_BITS-1:0] n_p [6];
    logic signed [WORD_BITS:0]   r_as2 [3];
    logic signed [WORD_BITS:0]   n_as [3];
    t_word                       m1 [6];
    t_word                       m2 [6];
    // stage 3
    logic                       r_v3;
    t_item                      r_it3;
    logic signed [ACC_BITS-1:0] r_w [3];
    logic signed [ACC_BITS-1:0] n_w [3];
    logic signed [ACC_BITS-1:0] r_ws;
    logic signed [WORD_BITS:0]  r_as3 [3];
    // stage 4
    logic                       r_v4;
    t_item                      r_it4;
    logic signed [ACC_BITS-1:0] r_q [3];
    logic signed [ACC_BITS-1:0] n_q [3];
    logic signed [ACC_BITS-1:0] r_qs;
    logic signed [ACC_BITS-1:0] n_qs;
    logic signed [WORD_BITS:0]  r_as4 [3];
    logic [PROD_BITS-1:0]       r_rad4;
    // stage 5
    logic                 r_v5;
    t_tag                 r_tag5;
    t_tag                 n_tag;
    logic [PROD_BITS-1:0] r_rad5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Products land in lane pairs: component i is lane 2i minus lane 2i+1.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            m1[i] = '0;
            m2[i] = '0;
        end
        unique case (r_it1.func) inside
            FN_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    m1[2*i] = r_it1.a[i];
                    m2[2*i] = r_it1.s;
                end
            end
            FN_CROSS: begin
                m1[0] = r_it1.a[1]; m2[0] = r_b1[2];
                m1[1] = r_it1.a[2]; m2[1] = r_b1[1];
                m1[2] = r_it1.a[2]; m2[2] = r_b1[0];
                m1[3] = r_it1.a[0]; m2[3] = r_b1[2];
                m1[4] = r_it1.a[0]; m2[4] = r_b1[1];
                m1[5] = r_it1.a[1]; m2[5] = r_b1[0];
            end
            FN_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    m1[2*i] = r_it1.a[i];
                    m2[2*i] = r_b1[i];
                end
            end
            FN_LENSQ, FN_LEN, FN_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    m1[2*i] = r_it1.a[i];
                    m2[2*i] = r_it1.a[i];
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 6; i++) begin
            n_p[i] = PROD_BITS'($signed(m1[i]) * $signed(m2[i]));
        end
        for (int i = 0; i < 3; i++) begin
            if (r_it1.func == FN_SUB) begin
                n_as[i] = (WORD_BITS+1)'($signed(r_it1.a[i])) - (WORD_BITS+1)'($signed(r_b1[i]));
            end else begin
                n_as[i] = (WORD_BITS+1)'($signed(r_it1.a[i])) + (WORD_BITS+1)'($signed(r_b1[i]));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_w[i] = ACC_BITS'(r_p[2*i]) - ACC_BITS'(r_p[2*i+1]);
        end
    end

    // Shift right with truncation toward zero.
    always_comb begin
        logic signed [ACC_BITS-1:0] bias;
        for (int i = 0; i < 3; i++) begin
            bias   = r_w[i][ACC_BITS-1] ? BIAS : '0;
            n_q[i] = (r_w[i] + bias) >>> FRAC_BITS;
        end
        bias = r_ws[ACC_BITS-1] ? BIAS : '0;
        n_qs = (r_ws + bias) >>> FRAC_BITS;
    end

    always_comb begin
        t_clamp c;
        c         = '0;
        n_tag.it  = r_it4;
        n_tag.r   = '0;
        n_tag.rs  = '0;
        n_tag.sat = 1'b0;
        unique case (r_it4.func) inside
            FN_ADD, FN_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    c          = clamp_acc(ACC_BITS'(r_as4[i]));
                    n_tag.r[i] = c.val;
                    n_tag.sat  = n_tag.sat | c.sat;
                end
            end
            FN_SCALE, FN_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    c          = clamp_acc(r_q[i]);
                    n_tag.r[i] = c.val;
                    n_tag.sat  = n_tag.sat | c.sat;
                end
            end
            FN_DOT, FN_LENSQ: begin
                c         = clamp_acc(r_qs);
                n_tag.rs  = c.val;
                n_tag.sat = c.sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_it1        <= '{func: i_func, a: i_a, s: i_s};
        r_b1         <= i_b;
        r_it2        <= r_it1;
        r_p          <= n_p;
        r_as2        <= n_as;
        r_it3        <= r_it2;
        r_w          <= n_w;
        r_ws         <= ACC_BITS'(r_p[0]) + ACC_BITS'(r_p[2]) + ACC_BITS'(r_p[4]);
        r_as3        <= r_as2;
        r_it4        <= r_it3;
        r_q          <= n_q;
        r_qs         <= n_qs;
        r_as4        <= r_as3;
        r_rad4       <= r_ws[PROD_BITS-1:0];
        r_tag5       <= n_tag;
        r_rad5       <= r_rad4;
    end

    assign o_valid = r_v5;
    assign o_tag   = r_tag5;
    assign o_rad   = r_rad5;

endmodule

FILE: hw/rtl/v3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module v3alu_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [v3alu_pkg::PROD_BITS-1:0]  i_rad,
    input  v3alu_pkg::t_tag                  i_tag,
    output logic                             o_valid,
    output logic [v3alu_pkg::ROOT_BITS-1:0]  o_root,
    output v3alu_pkg::t_tag                  o_tag
);
    import v3alu_pkg::*;

    localparam int N = SQRT_STAGES;

    logic                 r_v    [N];
    logic [PROD_BITS-1:0] r_rad  [N];
    logic [ROOT_BITS:0]   r_rem  [N];
    logic [ROOT_BITS-1:0] r_root [N];
    t_tag                 r_tag  [N];

    logic                 s_v    [N];
    logic [PROD_BITS-1:0] s_rad  [N];
    logic [ROOT_BITS:0]   s_rem  [N];
    logic [ROOT_BITS-1:0] s_root [N];
    t_tag                 s_tag  [N];

    logic [PROD_BITS-1:0] n_rad  [N];
    logic [ROOT_BITS:0]   n_rem  [N];
    logic [ROOT_BITS-1:0] n_root [N];

    always_comb begin
        s_v[0]    = i_valid;
        s_rad[0]  = i_rad;
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_tag[0]  = i_tag;
        for (int k = 1; k < N; k++) begin
            s_v[k]    = r_v[k-1];
            s_rad[k]  = r_rad[k-1];
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_tag[k]  = r_tag[k-1];
        end
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        logic [ROOT_BITS+2:0] rem_sh;
        logic [ROOT_BITS+2:0] trial;
        logic [ROOT_BITS+2:0] diff;
        logic                 ge;
        for (int k = 0; k < N; k++) begin
            rem_sh    = {s_rem[k], s_rad[k][PROD_BITS-1 -: 2]};
            trial     = {1'b0, s_root[k], 2'b01};
            diff      = rem_sh - trial;
            ge        = (rem_sh >= trial);
            n_rem[k]  = ge ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
            n_root[k] = {s_root[k][ROOT_BITS-2:0], ge};
            n_rad[k]  = {s_rad[k][PROD_BITS-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_v[k] <= 1'b0;
        end else begin
            r_v <= s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_tag  <= s_tag;
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

FILE: hw/rtl/v3alu_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module v3alu_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [v3alu_pkg::ROOT_BITS-1:0]       i_root,
    input  v3alu_pkg::t_tag                       i_tag,
    output logic                                  o_valid,
    output logic [v3alu_pkg::ROOT_BITS-1:0]       o_root,
    output v3alu_pkg::t_tag                       o_tag,
    output v3alu_pkg::t_dinfo                     o_info,
    output logic [2:0][v3alu_pkg::DVD_BITS-1:0]   o_q
);
    import v3alu_pkg::*;

    localparam int N = DIV_STAGES;

    logic                 r_v    [N];
    logic [DVD_BITS-1:0]  r_dvd  [N][3];
    logic [WORD_BITS-1:0] r_rem  [N][3];
    logic [WORD_BITS-1:0] r_den  [N];
    logic [ROOT_BITS-1:0] r_root [N];
    t_tag                 r_tag  [N];
    t_dinfo               r_info [N];

    logic                 s_v    [N];
    logic [DVD_BITS-1:0]  s_dvd  [N][3];
    logic [WORD_BITS-1:0] s_rem  [N][3];
    logic [WORD_BITS-1:0] s_den  [N];
    logic [ROOT_BITS-1:0] s_root [N];
    t_tag                 s_tag  [N];
    t_dinfo               s_info [N];

    logic [DVD_BITS-1:0]  n_dvd  [N][3];
    logic [WORD_BITS-1:0] n_rem  [N][3];

    logic [WORD_BITS-1:0] den0;
    logic [WORD_BITS-1:0] a_mag [3];
    t_dinfo               info0;
    logic                 is_norm;

    // Operands in magnitude form; signs are settled after the last stage.
    always_comb begin
        t_word s;
        s       = i_tag.it.s;
        is_norm = (i_tag.it.func == FN_NORM);
        den0    = is_norm ? WORD_BITS'(i_root)
                          : (s[WORD_BITS-1] ? (~s + 1'b1) : s);
        info0.den_zero = (den0 == '0);
        for (int i = 0; i < 3; i++) begin
            a_mag[i]     = i_tag.it.a[i][WORD_BITS-1] ? (~i_tag.it.a[i] + 1'b1) : i_tag.it.a[i];
            info0.neg[i] = i_tag.it.a[i][WORD_BITS-1] ^ (!is_norm && s[WORD_BITS-1]);
        end
    end

    always_comb begin
        s_v[0]    = i_valid;
        s_den[0]  = den0;
        s_root[0] = i_root;
        s_tag[0]  = i_tag;
        s_info[0] = info0;
        for (int i = 0; i < 3; i++) begin
            s_dvd[0][i] = {a_mag[i], {FRAC_BITS{1'b0}}};
            s_rem[0][i] = '0;
        end
        for (int k = 1; k < N; k++) begin
            s_v[k]    = r_v[k-1];
            s_den[k]  = r_den[k-1];
            s_root[k] = r_root[k-1];
            s_tag[k]  = r_tag[k-1];
            s_info[k] = r_info[k-1];
            for (int i = 0; i < 3; i++) begin
                s_dvd[k][i] = r_dvd[k-1][i];
                s_rem[k][i] = r_rem[k-1][i];
            end
        end
    end

    // Quotient bits shift in at the bottom as dividend bits leave the top.
    always_comb begin
        logic [WORD_BITS:0] r2;
        logic [WORD_BITS:0] diff;
        logic               ge;
        for (int k = 0; k < N; k++) begin
            for (int i = 0; i < 3; i++) begin
                r2          = {s_rem[k][i], s_dvd[k][i][DVD_BITS-1]};
                diff        = r2 - {1'b0, s_den[k]};
                ge          = (r2 >= {1'b0, s_den[k]});
                n_rem[k][i] = ge ? diff[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
                n_dvd[k][i] = {s_dvd[k][i][DVD_BITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_v[k] <= 1'b0;
        end else begin
            r_v <= s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_den  <= s_den;
        r_root <= s_root;
        r_tag  <= s_tag;
        r_info <= s_info;
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_tag   = r_tag[N-1];
    assign o_info  = r_info[N-1];
    assign o_q     = {r_dvd[N-1][2], r_dvd[N-1][1], r_dvd[N-1][0]};

endmodule

FILE: hw/rtl/vector3_alu.sv
// Top level of the pipelined Q16.16 3D vector unit.
//
//  channel   | direction | handshake                 | beat
//  ----------+-----------+---------------------------+----------------------------------
//  command   | in        | start, busy (always low)  | i_func, i_a_*, i_b_*, i_scalar_in
//  result    | out       | o_valid strobe, no stall  | o_r_x/y/z, o_r_scalar, o_saturated
//
// Every operation passes through the same path from accepted command to result strobe:
// 5 front-end stages (multipliers, sums, rescale, clamp), 32 square-root stages,
// 48 divider stages and one output register. A new command may enter every cycle.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so busy stays low and nothing is ever held back.
module vector3_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_func,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic [31:0] i_scalar_in,
    output logic        o_valid,
    output logic [31:0] o_r_x,
    output logic [31:0] o_r_y,
    output logic [31:0] o_r_z,
    output logic [31:0] o_r_scalar,
    output logic        o_saturated
);
    import v3alu_pkg::*;

    logic                      fr_valid;
    t_tag                      fr_tag;
    logic [PROD_BITS-1:0]      fr_rad;
    logic                      sq_valid;
    logic [ROOT_BITS-1:0]      sq_root;
    t_tag                      sq_tag;
    logic                      dv_valid;
    logic [ROOT_BITS-1:0]      dv_root;
    t_tag                      dv_tag;
    t_dinfo                    dv_info;
    logic [2:0][DVD_BITS-1:0]  dv_q;

    logic        r_out_valid;
    t_word [2:0] r_out_r;
    t_word       r_out_rs;
    logic        r_out_sat;
    t_word [2:0] n_out_r;
    t_word       n_out_rs;
    logic        n_out_sat;

    assign busy = 1'b0;

    v3alu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_func  (i_func),
        .i_a     ({i_a_z, i_a_y, i_a_x}),
        .i_b     ({i_b_z, i_b_y, i_b_x}),
        .i_s     (i_scalar_in),
        .o_valid (fr_valid),
        .o_tag   (fr_tag),
        .o_rad   (fr_rad)
    );

    v3alu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_rad   (fr_rad),
        .i_tag   (fr_tag),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    v3alu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_tag   (sq_tag),
        .o_valid (dv_valid),
        .o_root  (dv_root),
        .o_tag   (dv_tag),
        .o_info  (dv_info),
        .o_q     (dv_q)
    );

    // Late results: signed quotients, the zero-divisor pass-through and the length.
    always_comb begin
        t_clamp                    c;
        logic signed [DVD_BITS:0]  mag;
        logic signed [DVD_BITS:0]  val;
        c         = '0;
        mag       = '0;
        val       = '0;
        n_out_r   = dv_tag.r;
        n_out_rs  = dv_tag.rs;
        n_out_sat = dv_tag.sat;
        case (dv_tag.it.func) inside
            FN_DIV, FN_NORM: begin
                if (dv_info.den_zero) begin
                    n_out_r   = dv_tag.it.a;
                    n_out_sat = 1'b0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        mag        = $signed({1'b0, dv_q[i]});
                        val        = dv_info.neg[i] ? -mag : mag;
                        c          = clamp_acc(ACC_BITS'(val));
                        n_out_r[i] = c.val;
                        n_out_sat  = n_out_sat | c.sat;
                    end
                end
            end
            FN_LEN: begin
                c         = clamp_acc(ACC_BITS'($signed({1'b0, dv_root})));
                n_out_rs  = c.val;
                n_out_sat = c.sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_r   <= n_out_r;
        r_out_rs  <= n_out_rs;
        r_out_sat <= n_out_sat;
    end

    assign o_valid     = r_out_valid;
    assign o_r_x       = r_out_r[0];
    assign o_r_y       = r_out_r[1];
    assign o_r_z       = r_out_r[2];
    assign o_r_scalar  = r_out_rs;
    assign o_saturated = r_out_sat;

    a_latency_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("accepted command did not produce a result at the fixed latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LATENCY !o_valid)
        else $error("result strobe without a matching command");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_r_x == WORD_MAX || o_r_x == WORD_MIN || o_r_y == WORD_MAX ||
             o_r_y == WORD_MIN || o_r_z == WORD_MAX || o_r_z == WORD_MIN ||
             o_r_scalar == WORD_MAX || o_r_scalar == WORD_MIN))
        else $error("saturation flagged but no field sits at a range limit");

endmodule

FILE: tb/v3alu_checker.sv
// Checker for the 3D vector unit: predicts each command's result and compares the strobed beats.
module v3alu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [3:0]  i_func,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic [31:0] i_scalar_in,
    input  logic        o_valid,
    input  logic [31:0] o_r_x,
    input  logic [31:0] o_r_y,
    input  logic [31:0] o_r_z,
    input  logic [31:0] o_r_scalar,
    input  logic        o_saturated,
    output int          n_fail,
    output int          n_pending,
    output int          n_results
);
    import v3alu_pkg::*;

    typedef logic signed [127:0] t_big;

    typedef struct {
        t_word vx;
        t_word vy;
        t_word vz;
        t_word sc;
        logic  sat;
    } t_vec_result;

    t_vec_result results_due[$];

    initial begin
        n_fail    = 0;
        n_pending = 0;
        n_results = 0;
    end

    function automatic t_word sat_word(input t_big v, inout logic sat);
        if (v > t_big'(WORD_MAX)) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < t_big'(WORD_MIN)) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return t_word'(v[31:0]);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Signed division in SystemVerilog truncates toward zero, as the fixed-point rules require.
    function automatic t_vec_result vector_op(input logic [3:0] fn, input t_big a [3],
                                              input t_big b [3], input t_big s);
        t_vec_result res;
        t_big r [3];
        t_big acc;
        t_big len;
        logic sat;
        int j, k;
        sat = 1'b0;
        r = '{0, 0, 0};
        res.sc = '0;
        case (fn)
            FN_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            FN_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            FN_SCALE: for (int i = 0; i < 3; i++) r[i] = (a[i] * s) / (t_big'(1) << FRAC_BITS);
            FN_DIV:   for (int i = 0; i < 3; i++)
                          r[i] = (s == 0) ? a[i] : (a[i] * (t_big'(1) << FRAC_BITS)) / s;
            FN_CROSS: for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                r[i] = (a[j] * b[k] - a[k] * b[j]) / (t_big'(1) << FRAC_BITS);
            end
            FN_DOT: begin
                acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                res.sc = sat_word(acc / (t_big'(1) << FRAC_BITS), sat);
            end
            FN_LENSQ: begin
                acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                res.sc = sat_word(acc / (t_big'(1) << FRAC_BITS), sat);
            end
            FN_LEN, FN_NORM: begin
                acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                len = t_big'(floor_sqrt(acc[63:0]));
                if (fn == FN_LEN) res.sc = sat_word(len, sat);
                else for (int i = 0; i < 3; i++)
                    r[i] = (len == 0) ? a[i] : (a[i] * (t_big'(1) << FRAC_BITS)) / len;
            end
            default: ;
        endcase
        res.vx  = sat_word(r[0], sat);
        res.vy  = sat_word(r[1], sat);
        res.vz  = sat_word(r[2], sat);
        res.sat = sat;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_big a [3];
        t_big b [3];
        t_vec_result due;
        if (i_rst_n) begin
            if (start && !busy) begin
                a[0] = t_big'($signed(i_a_x));
                a[1] = t_big'($signed(i_a_y));
                a[2] = t_big'($signed(i_a_z));
                b[0] = t_big'($signed(i_b_x));
                b[1] = t_big'($signed(i_b_y));
                b[2] = t_big'($signed(i_b_z));
                results_due.push_back(vector_op(i_func, a, b, t_big'($signed(i_scalar_in))));
            end
            if (o_valid) begin
                n_results++;
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_fail++;
                end else begin
                    due = results_due.pop_front();
                    if (o_r_x !== due.vx) begin
                        $error("r_x expected %h actual %h", due.vx, o_r_x);
                        n_fail++;
                    end
                    if (o_r_y !== due.vy) begin
                        $error("r_y expected %h actual %h", due.vy, o_r_y);
                        n_fail++;
                    end
                    if (o_r_z !== due.vz) begin
                        $error("r_z expected %h actual %h", due.vz, o_r_z);
                        n_fail++;
                    end
                    if (o_r_scalar !== due.sc) begin
                        $error("r_scalar expected %h actual %h", due.sc, o_r_scalar);
                        n_fail++;
                    end
                    if (o_saturated !== due.sat) begin
                        $error("saturated expected %b actual %b", due.sat, o_saturated);
                        n_fail++;
                    end
                end
            end
            n_pending = results_due.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the 3D vector unit testbench: clock, reset, command stimulus and verdict.
module tb_top;
    import v3alu_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_func;
    logic [31:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_scalar_in;
    logic        o_valid;
    logic [31:0] o_r_x, o_r_y, o_r_z, o_r_scalar;
    logic        o_saturated;
    int          n_fail, n_pending, n_results;
    int          n_sent;
    int          idle_pct;
    int          idle_pct_list [4] = '{0, 48, 0, 17};

    localparam logic [31:0] W_MAX = WORD_MAX;
    localparam logic [31:0] W_MIN = WORD_MIN;
    localparam logic [31:0] ONE   = 32'h0001_0000;

    vector3_alu dut (.*);

    v3alu_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("** vector3_alu: FAILED **");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? W_MAX : W_MIN;
            1:       return '0;
            2, 3:    return 32'($signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
            4:       return 32'($signed($urandom_range(0, 64)) - 32) << FRAC_BITS;
            default: return $urandom();
        endcase
    endfunction

    // Drives one command beat and waits for the edge that takes it.
    task automatic send_cmd(input logic [3:0] fn, input logic [31:0] ax, ay, az,
                            input logic [31:0] bx, by, bz, sc);
        start       <= 1'b1;
        i_func      <= fn;
        i_a_x       <= ax;
        i_a_y       <= ay;
        i_a_z       <= az;
        i_b_x       <= bx;
        i_b_y       <= by;
        i_b_z       <= bz;
        i_scalar_in <= sc;
        @(posedge i_clk iff !busy);
        n_sent++;
    endtask

    task automatic send_random();
        logic [3:0]  fn;
        logic [31:0] sc;
        fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        sc = pick_word();
        if (fn == FN_DIV && $urandom_range(0, 9) == 0) sc = '0;
        if (fn == FN_NORM && $urandom_range(0, 9) == 0)
            send_cmd(fn, '0, '0, '0, pick_word(), pick_word(), pick_word(), sc);
        else
            send_cmd(fn, pick_word(), pick_word(), pick_word(),
                     pick_word(), pick_word(), pick_word(), sc);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
    endtask

    initial begin
        n_sent      = 0;
        start       = 1'b0;
        i_func      = '0;
        i_a_x       = '0;
        i_a_y       = '0;
        i_a_z       = '0;
        i_b_x       = '0;
        i_b_y       = '0;
        i_b_z       = '0;
        i_scalar_in = '0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, every operation, divide by zero, zero-vector normalize, unused codes.
        send_cmd(FN_ADD, W_MAX, W_MIN, ONE, W_MAX, W_MIN, 32'hFFFF_0000, '0);
        send_cmd(FN_ADD, 32'h1234_5678, 32'h8765_4321, '0, 32'h1111, 32'h2222, '1, '0);
        send_cmd(FN_SUB, W_MIN, W_MAX, '0, W_MAX, W_MIN, W_MIN, '0);
        send_cmd(FN_SUB, ONE, '1, 32'h7FFF, 32'h3, ONE, '1, '0);
        send_cmd(FN_SCALE, W_MAX, W_MIN, W_MIN, '0, '0, '0, W_MAX);
        send_cmd(FN_SCALE, W_MIN, W_MAX, 32'hFFFF_FFFF, '0, '0, '0, W_MIN);
        send_cmd(FN_SCALE, 32'h0003_8000, 32'hFFFF_FFFF, 32'h1, '0, '0, '0, 32'h0000_8000);
        send_cmd(FN_DIV, W_MAX, W_MIN, ONE, '0, '0, '0, '0);
        send_cmd(FN_DIV, W_MAX, W_MIN, 32'h0005_0000, '0, '0, '0, 32'h1);
        send_cmd(FN_DIV, W_MIN, W_MAX, 32'hFFFB_0000, '0, '0, '0, 32'hFFFF_0000);
        send_cmd(FN_DIV, 32'h0007_0000, 32'hFFF9_0000, 32'h1, '0, '0, '0, 32'h0003_0000);
        send_cmd(FN_DIV, W_MIN, ONE, '0, '0, '0, '0, W_MIN);
        send_cmd(FN_CROSS, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, '0);
        send_cmd(FN_CROSS, ONE, '0, '0, '0, ONE, '0, '0);
        send_cmd(FN_DOT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, '0);
        send_cmd(FN_DOT, W_MAX, W_MIN, 32'h0002_0000, W_MAX, W_MAX, 32'hFFFD_0000, '0);
        send_cmd(FN_LENSQ, W_MIN, W_MIN, W_MIN, '0, '0, '0, '0);
        send_cmd(FN_LENSQ, 32'h0001_8000, 32'hFFFF_0000, 32'h1, '0, '0, '0, '0);
        send_cmd(FN_LEN, W_MIN, W_MIN, W_MIN, '0, '0, '0, '0);
        send_cmd(FN_LEN, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0);
        send_cmd(FN_NORM, '0, '0, '0, W_MAX, W_MAX, W_MAX, W_MAX);
        send_cmd(FN_NORM, 32'h0003_0000, 32'hFFFC_0000, '0, '0, '0, '0, '0);
        send_cmd(FN_NORM, 32'h1, '0, '0, '0, '0, '0, '0);
        send_cmd(4'd9, W_MAX, W_MIN, ONE, W_MAX, W_MIN, ONE, W_MAX);
        send_cmd(4'd15, '1, '1, '1, '1, '1, '1, '1);

        // Hold off until the pipeline has handed back every result.
        drain();

        foreach (idle_pct_list[p]) begin
            idle_pct = idle_pct_list[p];
            repeat (375) begin
                // Each cycle is idle with the phase's probability.
                while ($urandom_range(1, 100) <= idle_pct) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                end
                send_random();
            end
        end

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d commands covering all nine operations and unused codes,", n_sent);
        $display("with %0d result beats checked under back-to-back and gapped traffic.",
                 n_results);
        if (n_fail == 0) begin
            $display("** vector3_alu: PASSED **");
        end else begin
            $display("** vector3_alu: FAILED **");
        end
        $finish;
    end

endmodule
